[rtl/asi_pkg.sv]
// shared types and constants for the segment intersection block
package asi_pkg;

    localparam int COORD_WIDTH = 16;
    localparam int SPAN_W      = COORD_WIDTH + 1;     // differences of two coordinates
    localparam int PROD_W      = 2 * SPAN_W;          // product of two span magnitudes
    localparam int FL_W        = COORD_WIDTH + 3;     // base coordinate plus signed quotient
    localparam int IN_W        = 8 * COORD_WIDTH;
    localparam int OUT_FIELD_W = 1 + 2 * COORD_WIDTH;
    localparam int OUT_W       = ((OUT_FIELD_W + 7) / 8) * 8;

    // everything an item carries alongside the division
    typedef struct packed {
        logic                          vert;      // line is x = c, else y = c
        logic                          fail;      // already known to miss
        logic                          coll;      // b runs parallel to the line
        logic                          coll_hit;
        logic signed [COORD_WIDTH-1:0] coll_v;
        logic signed [COORD_WIDTH-1:0] c;
        logic signed [COORD_WIDTH-1:0] lo;
        logic signed [COORD_WIDTH-1:0] hi;
        logic signed [COORD_WIDTH-1:0] v0;
        logic                          neg;       // quotient is negative: v1 lies below v0
    } asi_side_t;

    // one division cell's view of an item
    typedef struct packed {
        logic [SPAN_W-1:0] rem;
        logic [SPAN_W-1:0] low;
        logic [SPAN_W-1:0] quo;
        logic [SPAN_W-1:0] den;
        asi_side_t         side;
    } asi_div_t;

endpackage

[rtl/asi_front.sv]
// case selection, span set-up and the product ahead of the divider
module asi_front (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [asi_pkg::IN_W-1:0] in_data,
    output logic                    out_valid,
    input  logic                    out_ready,
    output asi_pkg::asi_div_t       out_data
);
    import asi_pkg::*;

    typedef logic signed [COORD_WIDTH-1:0] crd_t;
    typedef logic signed [SPAN_W:0]        wide_t;

    crd_t ax0, ay0, ax1, ay1, bx0, by0, bx1, by1;
    crd_t c, lo, hi, u0, v0, u1, v1, blo, bhi, olo, ohi;
    wide_t den, num, dv, den_n, num_n;
    logic vert, horz;
    asi_side_t side_next;

    logic                 a_valid_reg;
    asi_side_t            a_side_reg;
    logic [SPAN_W-1:0]    mag_reg, num_reg, den_reg;
    logic                 b_valid_reg;
    asi_side_t            b_side_reg;
    logic [PROD_W-1:0]    prod_reg;
    logic [SPAN_W-1:0]    den_b_reg;
    logic                 a_ready, b_ready;

    assign ax0 = $signed(in_data[0*COORD_WIDTH +: COORD_WIDTH]);
    assign ay0 = $signed(in_data[1*COORD_WIDTH +: COORD_WIDTH]);
    assign ax1 = $signed(in_data[2*COORD_WIDTH +: COORD_WIDTH]);
    assign ay1 = $signed(in_data[3*COORD_WIDTH +: COORD_WIDTH]);
    assign bx0 = $signed(in_data[4*COORD_WIDTH +: COORD_WIDTH]);
    assign by0 = $signed(in_data[5*COORD_WIDTH +: COORD_WIDTH]);
    assign bx1 = $signed(in_data[6*COORD_WIDTH +: COORD_WIDTH]);
    assign by1 = $signed(in_data[7*COORD_WIDTH +: COORD_WIDTH]);

    always_comb
    begin
        vert = (ax0 == ax1);
        horz = (ay0 == ay1);
        if (vert)
        begin
            c  = ax0;
            lo = (ay0 < ay1) ? ay0 : ay1;
            hi = (ay0 < ay1) ? ay1 : ay0;
            u0 = bx0; v0 = by0; u1 = bx1; v1 = by1;
        end
        else
        begin
            c  = ay0;
            lo = (ax0 < ax1) ? ax0 : ax1;
            hi = (ax0 < ax1) ? ax1 : ax0;
            u0 = by0; v0 = bx0; u1 = by1; v1 = bx1;
        end
        den = wide_t'(u1) - wide_t'(u0);
        num = wide_t'(c) - wide_t'(u0);
        dv  = wide_t'(v1) - wide_t'(v0);
        den_n = den[SPAN_W] ? -den : den;
        num_n = den[SPAN_W] ? -num : num;
        // overlap of the two spans when b lies on the line
        blo = (v0 < v1) ? v0 : v1;
        bhi = (v0 < v1) ? v1 : v0;
        olo = (lo > blo) ? lo : blo;
        ohi = (hi < bhi) ? hi : bhi;

        side_next.vert     = vert;
        side_next.coll     = (den == '0);
        // a slanted a never hits, even with b along one of its coordinates
        side_next.coll_hit = (vert || horz) && (u0 == c) && (olo <= ohi);
        side_next.coll_v   = olo;
        side_next.fail     = !(vert || horz) ||
                             (den != '0 && (num_n[SPAN_W] || num_n > den_n));
        side_next.c        = c;
        side_next.lo       = lo;
        side_next.hi       = hi;
        side_next.v0       = v0;
        side_next.neg      = dv[SPAN_W];
    end

    assign a_ready  = !a_valid_reg || b_ready;
    assign b_ready  = !b_valid_reg || out_ready;
    assign in_ready = a_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_ready)
                a_valid_reg <= in_valid;
            if (b_ready)
                b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_ready && in_valid)
        begin
            a_side_reg <= side_next;
            mag_reg    <= dv[SPAN_W] ? SPAN_W'(-dv) : SPAN_W'(dv);
            num_reg    <= SPAN_W'(num_n);
            den_reg    <= SPAN_W'(den_n);
        end
        if (b_ready && a_valid_reg)
        begin
            b_side_reg <= a_side_reg;
            prod_reg   <= PROD_W'(mag_reg) * PROD_W'(num_reg);
            den_b_reg  <= den_reg;
        end
    end

    assign out_valid     = b_valid_reg;
    assign out_data.rem  = prod_reg[PROD_W-1:SPAN_W];
    assign out_data.low  = prod_reg[SPAN_W-1:0];
    assign out_data.quo  = '0;
    assign out_data.den  = den_b_reg;
    assign out_data.side = b_side_reg;

endmodule

[rtl/asi_div_cell.sv]
// one restoring division cell: one quotient bit per item
module asi_div_cell (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  asi_pkg::asi_div_t in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output asi_pkg::asi_div_t out_data
);
    import asi_pkg::*;

    logic              valid_reg;
    asi_div_t          data_reg;
    asi_div_t          data_next;
    logic [SPAN_W:0]   trial;
    logic [SPAN_W:0]   diff;

    always_comb
    begin
        trial     = {in_data.rem, in_data.low[SPAN_W-1]};
        diff      = trial - {1'b0, in_data.den};
        data_next = in_data;
        data_next.low = {in_data.low[SPAN_W-2:0], 1'b0};
        if (!diff[SPAN_W])
        begin
            data_next.rem = diff[SPAN_W-1:0];
            data_next.quo = {in_data.quo[SPAN_W-2:0], 1'b1};
        end
        else
        begin
            data_next.rem = trial[SPAN_W-1:0];
            data_next.quo = {in_data.quo[SPAN_W-2:0], 1'b0};
        end
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

`ifndef NO_ASSERTIONS
    // partial remainder stays below the divisor for items that need the quotient
    a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && !data_reg.side.fail && !data_reg.side.coll |-> data_reg.rem < data_reg.den)
        else $error("remainder not below divisor");
    // a stalled cell keeps its item
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && !out_ready |=> valid_reg && $stable(data_reg))
        else $error("stalled cell lost its item");
`endif

endmodule

[rtl/asi_back.sv]
// rounding, span checks and the output register
module asi_back (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  asi_pkg::asi_div_t            in_data,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [asi_pkg::OUT_W-1:0]    out_data
);
    import asi_pkg::*;

    typedef logic signed [FL_W-1:0] fl_t;

    fl_t  q_pos, q, fl, lo, hi;
    logic frac, hit_next;
    logic signed [COORD_WIDTH-1:0] hv, hx, hy;
    logic                          valid_reg;
    logic [OUT_W-1:0]              data_reg;

    always_comb
    begin
        frac  = (in_data.rem != '0);
        q_pos = $signed({{(FL_W-SPAN_W){1'b0}}, in_data.quo});
        // floor of a negative quotient: ~x is -x-1
        q     = in_data.side.neg ? (frac ? ~q_pos : -q_pos) : q_pos;
        fl    = fl_t'(in_data.side.v0) + q;
        lo    = fl_t'(in_data.side.lo);
        hi    = fl_t'(in_data.side.hi);
        if (in_data.side.coll)
        begin
            hit_next = in_data.side.coll_hit;
            hv       = in_data.side.coll_v;
        end
        else
        begin
            hit_next = !in_data.side.fail && !(fl < lo) && !(frac ? (fl >= hi) : (fl > hi));
            hv       = (frac && fl[FL_W-1]) ? COORD_WIDTH'(fl + 1) : COORD_WIDTH'(fl);
        end
        hx = in_data.side.vert ? in_data.side.c : hv;
        hy = in_data.side.vert ? hv : in_data.side.c;
        if (!hit_next)
        begin
            hx = '0;
            hy = '0;
        end
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            data_reg <= OUT_W'({hy, hx, hit_next});
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

[rtl/axis_segment_intersection.sv]
// top level: streaming segment intersection with a pipelined divider chain
// One item (two segments) in, one item (hit flag and point) out. The block
// is fully pipelined and takes one item per cycle while m_tready stays high.
// It has two set-up stages (span selection, then the 17x17 product), 17 division
// cells each settling one quotient bit, and the output register. Every stage
// has its own valid bit and stalls only when the stage after it is full, so a
// held result at the output does not stop new items from entering while
// bubbles remain. No state survives an item and reset only clears valid bits.
module axis_segment_intersection (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // a_x0, a_y0, a_x1, a_y1, b_x0, b_y0, b_x1, b_y1, 16 bits each
    input  logic [asi_pkg::IN_W-1:0]      s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // hit [0], hit_x [16:1], hit_y [32:17], zero fill above
    output logic [asi_pkg::OUT_W-1:0]     m_tdata
);
    import asi_pkg::*;

    // handshake and payload between the chain's links
    logic     chain_valid [SPAN_W+1];
    logic     chain_ready [SPAN_W+1];
    asi_div_t chain_data  [SPAN_W+1];

    // case selection and product
    asi_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (s_tdata),
        .out_valid (chain_valid[0]),
        .out_ready (chain_ready[0]),
        .out_data  (chain_data[0])
    );

    // one cell per quotient bit, most significant first
    for (genvar i = 0; i < SPAN_W; i++)
    begin : g_cell
        asi_div_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (chain_valid[i]),
            .in_ready  (chain_ready[i]),
            .in_data   (chain_data[i]),
            .out_valid (chain_valid[i+1]),
            .out_ready (chain_ready[i+1]),
            .out_data  (chain_data[i+1])
        );
    end

    // rounding toward zero, span checks, output register
    asi_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (chain_valid[SPAN_W]),
        .in_ready  (chain_ready[SPAN_W]),
        .in_data   (chain_data[SPAN_W]),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata)
    );

`ifndef NO_ASSERTIONS
    // a miss reports a zero point
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[0] |-> m_tdata[OUT_W-1:1] == '0)
        else $error("miss with a non-zero point");
`endif

endmodule
